[design/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths and defaults for the exponentiation core and its multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int FIELD_W           = 31;
    localparam int OPERAND_WIDTH_DEF = 31;

endpackage

[design/mexp_modmul.sv]
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Interleaved shift-and-add: one bit of the multiplier per cycle, MSB first,
// with the partial result kept below the modulus after every step.
// ----------------------------------------------------------------------------
module mexp_modmul
    import mexp_pkg::*;
#(
    parameter int W = OPERAND_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_mult,
    input  logic [W-1:0] i_mcand,
    input  logic [W:0]   i_mod,
    output logic         o_done,
    output logic [W-1:0] o_prod
);

    localparam int CNT_W = $clog2(W + 1);
    localparam int X     = W + 3;

    logic [W-1:0]     r_shift;
    logic [W-1:0]     r_mcand;
    logic [W-1:0]     r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [X-1:0] c0;
    logic [X-1:0] c1;
    logic [X-1:0] c2;
    logic [W-1:0] n_acc;

    // 2r + bit*b < 3m, so at most two subtractions of m
    always_comb begin
        c0 = X'({r_acc, 1'b0}) + (r_shift[W-1] ? X'(r_mcand) : X'(0));
        c1 = c0 - X'(i_mod);
        c2 = c0 - X'({i_mod, 1'b0});
        if (!c2[X-1]) begin
            n_acc = c2[W-1:0];
        end else if (!c1[X-1]) begin
            n_acc = c1[W-1:0];
        end else begin
            n_acc = c0[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_shift <= i_mult;
                r_mcand <= i_mcand;
                r_acc   <= '0;
                r_cnt   <= CNT_W'(W);
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_shift <= {r_shift[W-2:0], 1'b0};
                r_acc   <= n_acc;
                r_cnt   <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod = r_acc;

endmodule

[design/modular_exponentiation_core.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Right-to-left square-and-multiply; the square and the multiply of each
// exponent bit run side by side on two bit-serial modular multipliers.
// ----------------------------------------------------------------------------
// Operation: a zero exponent returns one in the cycle after start; otherwise the
// core first reduces the base, then runs one square-and-multiply step per exponent
// bit up to the highest set bit, each multiply taking one multiplier bit per cycle.
// Throughput: one request at a time; busy stays high until the result strobe.
// Results cannot be stalled. Reset is synchronous and sets the modulus to 1.
module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FIELD_W-1:0] i_cfg_wdata,
    input  logic               start,
    input  logic [FIELD_W-1:0] i_base,
    input  logic [FIELD_W-1:0] i_exponent,
    output logic               busy,
    output logic               o_valid,
    output logic [FIELD_W-1:0] o_result
);

    localparam int W = OPERAND_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BASE,
        S_LOOP
    } t_state;

    t_state       r_state;
    logic         r_go;
    logic [W-1:0] r_mod;
    logic [W-1:0] r_e;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_sq;

    logic [W:0]   mod_eff;
    logic [W-1:0] one_red;
    logic [W-1:0] mult_a;
    logic [W-1:0] mcand_a;
    logic         go_b;
    logic         done_a;
    logic         done_b;
    logic [W-1:0] prod_a;
    logic [W-1:0] prod_b;
    logic [W-1:0] n_acc;

    // a zero modulus reduces modulo 2^W
    assign mod_eff = {(r_mod == '0), r_mod};
    assign one_red = (r_mod == W'(1)) ? '0 : W'(1);

    assign mult_a  = (r_state == S_LOOP) ? r_acc : r_sq;
    assign mcand_a = (r_state == S_LOOP) ? r_sq  : one_red;
    assign go_b    = r_go && (r_state == S_LOOP);
    assign n_acc   = r_e[0] ? prod_a : r_acc;

    mexp_modmul #(
        .W (W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_mult  (mult_a),
        .i_mcand (mcand_a),
        .i_mod   (mod_eff),
        .o_done  (done_a),
        .o_prod  (prod_a)
    );

    mexp_modmul #(
        .W (W)
    ) u_sqr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (go_b),
        .i_mult  (r_sq),
        .i_mcand (r_sq),
        .i_mod   (mod_eff),
        .o_done  (done_b),
        .o_prod  (prod_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_mod   <= W'(1);
            busy    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_go    <= 1'b0;
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_mod <= i_cfg_wdata[W-1:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_exponent[W-1:0] == '0) begin
                            o_valid  <= 1'b1;
                            o_result <= FIELD_W'(1);
                        end else begin
                            r_e     <= i_exponent[W-1:0];
                            r_sq    <= i_base[W-1:0];
                            r_go    <= 1'b1;
                            busy    <= 1'b1;
                            r_state <= S_BASE;
                        end
                    end
                end
                S_BASE: begin
                    if (done_a) begin
                        r_sq    <= prod_a;
                        r_acc   <= one_red;
                        r_go    <= 1'b1;
                        r_state <= S_LOOP;
                    end
                end
                S_LOOP: begin
                    if (done_a) begin
                        r_acc <= n_acc;
                        r_sq  <= prod_b;
                        r_e   <= r_e >> 1;
                        if (r_e[W-1:1] == '0) begin
                            o_valid  <= 1'b1;
                            o_result <= FIELD_W'(n_acc);
                            busy     <= 1'b0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_go <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    busy    <= 1'b0;
                end
            endcase
        end
    end

    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_units_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_b |-> done_a)
        else $error("square and multiply units out of step");

    a_zero_exponent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_exponent[W-1:0] == '0))
            |=> (o_valid && (o_result == FIELD_W'(1))))
        else $error("zero exponent did not return one");

endmodule
